// ===== hw/rtl/ptst_pkg.sv =====
// Package for the periodic timer slot table: command and result codes,
// word structs and the chain word that travels from cell to cell.
// No dependencies.
package ptst_pkg;

  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_SCAN     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_DONE       = 3'd2,
    KIND_FIRED      = 3'd3,
    KIND_NONE       = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period;
    logic [15:0] handler_tag;
    logic [7:0]  slot_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot_num;
    logic [15:0] fired_tag;
    logic        last;
  } out_t;

  // Command word as it walks the chain, with the result still held back.
  typedef struct packed {
    logic                  active;
    logic [1:0]            cmd;
    logic [15:0]           period;
    logic [15:0]           tag;
    logic [7:0]            slot_id;
    logic [FIRE_CNT_W-1:0] nfire;
    logic                  pend_vld;
    logic [2:0]            pend_slot;
    logic [15:0]           pend_tag;
  } chain_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  slot_num;
    logic [15:0] fired_tag;
  } emit_t;

endpackage

// ===== hw/rtl/periodic_timer_slot_table_core.sv =====
// Top level of the periodic timer slot table: entry register, chain of
// slot cells and the result register.
// Depends on ptst_pkg and ptst_cell.
//
// Usage: a command word enters on in_valid_i / in_stall_o / in_word_i
// (register, remove, tick, scan) and results leave on out_valid_o /
// out_stall_i / out_word_o. A word is taken at a rising edge where valid
// is high and stall is low, on either channel.
// The command word is caught in an entry register, then walks the row of
// NumSlots cells, one cell a cycle when not stalled; each cell holds one
// slot and acts on the word as it passes (claim, free, count, fire).
// Every command ends in exactly one result with last set. A scan gives one
// fired result per due slot in slot order, at most MAX_RESULTS of them;
// each fired result is held back one step so the final one can be marked.
// The final result is registered after the word has passed the entry
// register and every cell. One command is in flight at a time: a new
// command is taken only once the previous one has left the cell chain;
// in_stall_o is high while a command walks.
// A stalled output freezes the whole chain, so no result is lost.
// Reset clears all slots (valid, period, count) and the chain; slot tags
// are loaded on register and need no reset. No clearing pass is needed.
module periodic_timer_slot_table_core import ptst_pkg::*; #(
  parameter int unsigned NumSlots = NUM_SLOTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_word_o
);

  chain_t head_q, head_d;
  chain_t chain_w [NumSlots+1];
  emit_t  emits   [NumSlots];
  emit_t  emit_any;
  chain_t tail;
  logic   en;
  logic   busy;
  logic   accept;
  logic   out_vld_q, out_vld_d;
  out_t   out_q, out_d;

  // Advance the chain only when the result register can take a word.
  assign en     = !out_vld_q || !out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    busy = head_q.active;
    for (int i = 1; i <= NumSlots; i++) begin
      busy = busy | chain_w[i].active;
    end
  end

  assign in_stall_o = busy;

  // Entry register: load a new command, drop it once cell 0 has it.
  always_comb begin
    head_d = head_q;
    if (accept) begin
      head_d             = '0;
      head_d.active      = 1'b1;
      head_d.cmd         = in_word_i.cmd;
      head_d.period      = in_word_i.period;
      head_d.tag         = in_word_i.handler_tag;
      head_d.slot_id     = in_word_i.slot_id;
    end else if (en) begin
      head_d.active = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain_w[0] = head_q;

  for (genvar g = 0; g < NumSlots; g++) begin : g_cell
    ptst_cell #(
      .SlotIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (chain_w[g]),
      .word_o (chain_w[g+1]),
      .emit_o (emits[g])
    );
  end

  // Only the cell holding the live word can emit, so OR the lanes together.
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < NumSlots; i++) begin
      emit_any = emit_any | emits[i];
    end
  end

  assign tail = chain_w[NumSlots];

  // Pick the next result: an early fired result, or the closing one.
  always_comb begin
    out_d     = '0;
    out_vld_d = 1'b0;
    if (emit_any.vld) begin
      out_vld_d        = 1'b1;
      out_d.kind       = KIND_FIRED;
      out_d.slot_num   = emit_any.slot_num;
      out_d.fired_tag  = emit_any.fired_tag;
      out_d.last       = 1'b0;
    end else if (tail.active) begin
      out_vld_d  = 1'b1;
      out_d.last = 1'b1;
      case (tail.cmd)
        CMD_REGISTER: begin
          if (tail.pend_vld) begin
            out_d.kind      = KIND_REGISTERED;
            out_d.slot_num  = tail.pend_slot;
            out_d.fired_tag = tail.pend_tag;
          end else begin
            out_d.kind = KIND_FULL;
          end
        end
        CMD_SCAN: begin
          if (tail.pend_vld) begin
            out_d.kind      = KIND_FIRED;
            out_d.slot_num  = tail.pend_slot;
            out_d.fired_tag = tail.pend_tag;
          end else begin
            out_d.kind = KIND_NONE;
          end
        end
        default: begin
          out_d.kind = KIND_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && out_vld_d) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/ptst_cell.sv =====
// One slot of the timer table: valid, period, count and tag, plus the
// register that hands the command word on to the next cell.
// Depends on ptst_pkg.
module ptst_cell import ptst_pkg::*; #(
  parameter int unsigned SlotIdx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  chain_t word_i,
  output chain_t word_o,
  output emit_t  emit_o
);

  logic        valid_q, valid_d;
  logic [15:0] period_q, period_d;
  logic [15:0] count_q, count_d;
  logic [15:0] tag_q;
  chain_t      word_q, word_d;
  logic        fire, claim, rm, tick;

  always_comb begin
    fire  = word_i.active && (word_i.cmd == CMD_SCAN) && valid_q &&
            (count_q >= period_q) &&
            (word_i.nfire < FIRE_CNT_W'(MAX_RESULTS));
    claim = word_i.active && (word_i.cmd == CMD_REGISTER) &&
            !word_i.pend_vld && !valid_q;
    rm    = word_i.active && (word_i.cmd == CMD_REMOVE) &&
            (word_i.slot_id == 8'(SlotIdx));
    tick  = word_i.active && (word_i.cmd == CMD_TICK);
  end

  // Next word: record a firing or a claim as the pending result.
  always_comb begin
    word_d = word_i;
    if (fire) begin
      word_d.nfire     = word_i.nfire + FIRE_CNT_W'(1);
      word_d.pend_vld  = 1'b1;
      word_d.pend_slot = 3'(SlotIdx);
      word_d.pend_tag  = tag_q;
    end else if (claim) begin
      word_d.pend_vld  = 1'b1;
      word_d.pend_slot = 3'(SlotIdx);
      word_d.pend_tag  = word_i.tag;
    end
  end

  // A new firing releases the one held before it, which is then not the last.
  always_comb begin
    emit_o.vld       = fire && word_i.pend_vld;
    emit_o.slot_num  = word_i.pend_slot;
    emit_o.fired_tag = word_i.pend_tag;
  end

  always_comb begin
    valid_d  = valid_q;
    period_d = period_q;
    count_d  = count_q;
    if (claim) begin
      valid_d  = 1'b1;
      period_d = word_i.period;
      count_d  = '0;
    end else if (rm) begin
      valid_d  = 1'b0;
      period_d = '0;
    end else if (fire) begin
      count_d  = '0;
    end else if (tick) begin
      count_d  = count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      period_q <= '0;
      count_q  <= '0;
      word_q   <= '0;
    end else if (en_i) begin
      valid_q  <= valid_d;
      period_q <= period_d;
      count_q  <= count_d;
      word_q   <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && claim) begin
      tag_q <= word_i.tag;
    end
  end

  assign word_o = word_q;

endmodule

// ===== tb/tb_periodic_timer_slot_table_core.sv =====
// Self-checking bench for periodic_timer_slot_table_core: directed and random
// command words, each result word checked against an in-bench slot table.
// Depends on ptst_pkg and the core RTL only.
module tb_periodic_timer_slot_table_core import ptst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest legal gap is the long receiver hold plus one chain walk.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned MAX_PRINTED    = 40;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_word   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;

  // Shared knobs between the test tasks and the receiver process.
  bit idle_on  = 1'b0;
  bit hold_req = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned quiet_ticks = 0;

  // Bench copy of the slot table, advanced once per accepted command word.
  logic        live      [NUM_SLOTS];
  logic [15:0] period_of [NUM_SLOTS];
  logic [15:0] count_of  [NUM_SLOTS];
  logic [15:0] tag_of    [NUM_SLOTS];

  // Result words still owed by the block, oldest first.
  out_t awaited_results[$];

  periodic_timer_slot_table_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_t result_word(input kind_e k, input logic [2:0] s,
                                       input logic [15:0] t, input logic l);
    out_t r;
    r.kind      = k;
    r.slot_num  = s;
    r.fired_tag = t;
    r.last      = l;
    return r;
  endfunction

  function automatic in_t cmd_word(input cmd_e c, input logic [15:0] p,
                                   input logic [15:0] t, input logic [7:0] id);
    in_t w;
    w.cmd         = c;
    w.period      = p;
    w.handler_tag = t;
    w.slot_id     = id;
    return w;
  endfunction

  // Advance the bench table by one command and queue the results it owes.
  task automatic step_slot_table(input in_t w);
    int   n;
    bit   taken;
    out_t tail;
    n     = 0;
    taken = 1'b0;
    case (w.cmd)
      CMD_REGISTER: begin
        // Claim the lowest free slot; the count restarts from zero.
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!taken && !live[s]) begin
            live[s]      = 1'b1;
            period_of[s] = w.period;
            count_of[s]  = '0;
            tag_of[s]    = w.handler_tag;
            awaited_results.push_back(result_word(KIND_REGISTERED, 3'(s),
                                                  w.handler_tag, 1'b1));
            taken = 1'b1;
          end
        end
        if (!taken) awaited_results.push_back(result_word(KIND_FULL, 3'd0, 16'd0, 1'b1));
      end
      CMD_REMOVE: begin
        // Out-of-range ids leave the table alone; the count is never touched.
        if (w.slot_id < NUM_SLOTS) begin
          live[w.slot_id]      = 1'b0;
          period_of[w.slot_id] = '0;
        end
        awaited_results.push_back(result_word(KIND_DONE, 3'd0, 16'd0, 1'b1));
      end
      CMD_TICK: begin
        // Every count moves, free slots too, wrapping at 16 bits.
        for (int s = 0; s < NUM_SLOTS; s++) count_of[s] = count_of[s] + 16'd1;
        awaited_results.push_back(result_word(KIND_DONE, 3'd0, 16'd0, 1'b1));
      end
      CMD_SCAN: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (n < MAX_RESULTS && live[s] && count_of[s] >= period_of[s]) begin
            count_of[s] = '0;
            awaited_results.push_back(result_word(KIND_FIRED, 3'(s), tag_of[s], 1'b0));
            n++;
          end
        end
        if (n == 0) begin
          awaited_results.push_back(result_word(KIND_NONE, 3'd0, 16'd0, 1'b1));
        end else begin
          // Mark the final fired word of the scan.
          tail      = awaited_results.pop_back();
          tail.last = 1'b1;
          awaited_results.push_back(tail);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one command word and hold it until taken. Valid stays high on
  // return, so a following call does not lower and raise it in one step.
  task automatic send_word(input in_t w);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      do begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end while ($urandom_range(0, 2) == 0);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    step_slot_table(w);
  endtask

  // Mostly well-formed traffic: short periods so slots really fire, slot ids
  // mostly in range, with the odd full-width value thrown in.
  function automatic in_t random_word();
    in_t w;
    int  sel;
    sel           = $urandom_range(0, 9);
    w.period      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    w.handler_tag = 16'($urandom);
    w.slot_id     = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, NUM_SLOTS));
    if (sel < 3)      w.cmd = CMD_REGISTER;
    else if (sel < 5) w.cmd = CMD_REMOVE;
    else if (sel < 8) w.cmd = CMD_TICK;
    else              w.cmd = CMD_SCAN;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Receiver: short random stalls, or one long counted hold on request.
  initial begin : receiver_stall
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result word with the oldest one owed.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word", 16'(out_word.kind), 16'd0);
      end else begin
        want = awaited_results.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch("kind", 16'(out_word.kind), 16'(want.kind));
        if (out_word.slot_num !== want.slot_num)
          report_mismatch("slot_num", 16'(out_word.slot_num), 16'(want.slot_num));
        if (out_word.fired_tag !== want.fired_tag)
          report_mismatch("fired_tag", out_word.fired_tag, want.fired_tag);
        if (out_word.last !== want.last)
          report_mismatch("last", 16'(out_word.last), 16'(want.last));
      end
    end
  end

  // Hang detector: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_ticks <= 0;
    end else if (quiet_ticks >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_ticks <= quiet_ticks + 1;
    end
  end

  // A slot with the widest period stays quiet over a few ticks, while a
  // period-one slot beside it fires once its count catches up.
  task automatic test_long_period();
    idle_on = 1'b0;
    send_word(cmd_word(CMD_REGISTER, 16'hFFFF, 16'h1234, 8'd0));
    send_word(cmd_word(CMD_TICK, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_REGISTER, 16'd1, 16'hEDCB, 8'd0));
    send_word(cmd_word(CMD_SCAN, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_TICK, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_SCAN, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'd1));
  endtask

  // Scan an empty table, fill it with period-zero slots carrying extreme
  // tags, fire all of them in one scan, then overflow it.
  task automatic test_fill_table();
    logic [15:0] tags [NUM_SLOTS];
    tags = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF, 16'h00FF};
    idle_on = 1'b1;
    send_word(cmd_word(CMD_SCAN, 16'd0, 16'd0, 8'd0));
    for (int s = 0; s < NUM_SLOTS; s++)
      send_word(cmd_word(CMD_REGISTER, 16'd0, tags[s], 8'd0));
    send_word(cmd_word(CMD_SCAN, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_word(cmd_word(CMD_REGISTER, 16'hFFFF, 16'hFFFF, 8'hFF));
  endtask

  // Free a valid slot, free it again, try ids past the table, then reuse the
  // freed slot with a longer period and watch it lag the others.
  task automatic test_remove_cases();
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'd7));
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'd7));
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'(NUM_SLOTS)));
    send_word(cmd_word(CMD_REMOVE, 16'd0, 16'd0, 8'hFF));
    send_word(cmd_word(CMD_REGISTER, 16'd3, 16'hBEEF, 8'd0));
    send_word(cmd_word(CMD_TICK, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_SCAN, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_TICK, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_TICK, 16'd0, 16'd0, 8'd0));
    send_word(cmd_word(CMD_SCAN, 16'd0, 16'd0, 8'd0));
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    repeat (50) send_word(random_word());
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so
  // the chain freezes and the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) send_word(random_word());
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_quiet_finish();
    idle_on = 1'b0;
    repeat (20) send_word(random_word());
  endtask

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      live[s]      = 1'b0;
      period_of[s] = '0;
      count_of[s]  = '0;
      tag_of[s]    = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_long_period();
    test_fill_table();
    test_remove_cases();
    test_random_traffic();
    test_backpressure();
    test_quiet_finish();
    in_valid <= 1'b0;

    // Drain, then give the chain time to show any stray word.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 4) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
